@@ rtl/core/mcfe_pkg.sv @@
// ============================================================================
// mcfe_pkg - motor command frame encoder shared definitions
// Stream layouts, quantiser constants, reciprocals and float helpers.
// ============================================================================
`default_nettype none

package mcfe_pkg;

    // Pipeline depth: input register, three work stages, output register
    localparam int NUM_STAGES = 5;

    // Mode codes (anything else is MIT mode)
    localparam logic [1:0] MODE_POS_VEL = 2'd1;
    localparam logic [1:0] MODE_VEL     = 2'd2;

    // CAN identifier offsets
    localparam logic [9:0] PV_OFFSET = 10'h100;
    localparam logic [9:0] V_OFFSET  = 10'h200;

    // Input stream layout
    localparam int IN_TDATA_W = 152;
    localparam int IN_TUSER_W = 2;
    localparam int IN_ID_LSB  = 0;
    localparam int IN_POS_LSB = 8;
    localparam int IN_VEL_LSB = 40;
    localparam int IN_KP_LSB  = 72;
    localparam int IN_KD_LSB  = 97;
    localparam int IN_TQ_LSB  = 116;
    localparam int KP_W       = 25;
    localparam int KD_W       = 19;

    // Output stream layout
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FID_W   = 10;
    localparam int OUT_BYTES   = 8;

    // Clamp limits in Q16 and offset-binary ranges
    localparam logic signed [31:0] POS_LIM   = 32'sd819200;
    localparam logic signed [31:0] POS_LIM_N = -32'sd819200;
    localparam logic        [20:0] POS_UMAX  = 21'd1638400;
    localparam logic        [20:0] POS_OFS   = 21'd819200;
    localparam logic signed [31:0] VEL_LIM   = 32'sd2949120;
    localparam logic signed [31:0] VEL_LIM_N = -32'sd2949120;
    localparam logic        [22:0] VEL_UMAX  = 23'd5898240;
    localparam logic        [22:0] VEL_OFS   = 23'd2949120;
    localparam logic signed [31:0] TQ_LIM    = 32'sd655360;
    localparam logic signed [31:0] TQ_LIM_N  = -32'sd655360;
    localparam logic        [20:0] TQ_UMAX   = 21'd1310720;
    localparam logic        [20:0] TQ_OFS    = 21'd655360;

    // Divisors left after the scale by 2^16, and floor(2^32 / divisor)
    localparam int unsigned POS_DIV = 25;
    localparam int unsigned VEL_DIV = 90;
    localparam int unsigned TQ_DIV  = 20;
    localparam int unsigned KP_DIV  = 500;
    localparam int unsigned KD_DIV  = 5;
    localparam logic [27:0] POS_RECIP = 28'd171798691;
    localparam logic [25:0] VEL_RECIP = 26'd47721858;
    localparam logic [27:0] TQ_RECIP  = 28'd214748364;
    localparam logic [23:0] KP_RECIP  = 24'd8589934;
    localparam logic [29:0] KD_RECIP  = 30'd858993459;

    localparam logic [11:0] CODE12_MAX = 12'd4095;
    localparam logic [7:0]  F32_EXP_BASE = 8'd111;

    // Float conversion pipeline contents
    typedef struct packed {
        logic        sign;
        logic [31:0] mag;
    } t_f32_mag;

    typedef struct packed {
        logic        sign;
        logic        zero;
        logic [31:0] mag;
        logic [4:0]  msb;
    } t_f32_lzc;

    typedef struct packed {
        logic        sign;
        logic        zero;
        logic [7:0]  expo;
        logic [31:0] norm;
    } t_f32_norm;

    // Index of the highest set bit (zero for a zero word)
    function automatic logic [4:0] f_msb_index(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // Signed Q16 to magnitude and sign
    function automatic t_f32_mag f_f32_mag(input logic [31:0] v);
        t_f32_mag m;
        m.sign = v[31];
        m.mag  = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

    // Round a normalised word to single precision, nearest even
    function automatic logic [31:0] f_f32_round(input t_f32_norm a);
        logic        up;
        logic [24:0] m;
        logic [7:0]  e;
        up = a.norm[7] & ((|a.norm[6:0]) | a.norm[8]);
        m  = {1'b0, a.norm[31:8]} + 25'(up);
        e  = a.expo + 8'(m[24]);
        return a.zero ? 32'd0 : {a.sign, e, m[22:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/motor_command_frame_encoder.sv @@
// ============================================================================
// motor_command_frame_encoder - motor command to CAN frame
// Quantises and packs MIT-mode commands, or converts position/velocity
// to single precision, and emits the identifier and eight payload bytes.
// ============================================================================
// Throughput: one item per cycle while the output is not stalled; five
// registered stages, each with its own valid bit, so bubbles close up and
// input is taken while a result waits.
// The per-stage ready chain from the output register sets the stall path.
// Reset (i_rst_n low, synchronous) empties the pipeline by clearing only the valid bits.
`default_nettype none

module motor_command_frame_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // motor_id[7:0], position[39:8], velocity[71:40], stiffness_gain[96:72],
    // damping_gain[115:97], torque[147:116], zero pad
    input  logic [mcfe_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // mode[1:0]
    input  logic [mcfe_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // frame_identifier[9:0], byte0[17:10] .. byte7[73:66], zero pad
    output logic [mcfe_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import mcfe_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // ------------------------------------------------------------------
    // Handshake: each stage loads when empty or when the next one loads
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] stage_rdy;
    logic [NUM_STAGES-1:0] r_vld;

    always_comb begin
        stage_rdy[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = stage_rdy[0];
    assign o_m_axis_tvalid = r_vld[LAST];

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic [7:0]         r_s0_id;
    logic [1:0]         r_s0_mode;
    logic signed [31:0] r_s0_pos;
    logic signed [31:0] r_s0_vel;
    logic [KP_W-1:0]    r_s0_kp;
    logic [KD_W-1:0]    r_s0_kd;
    logic signed [31:0] r_s0_tq;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_s0_id   <= i_s_axis_tdata[IN_ID_LSB +: 8];
            r_s0_mode <= i_s_axis_tuser[1:0];
            r_s0_pos  <= i_s_axis_tdata[IN_POS_LSB +: 32];
            r_s0_vel  <= i_s_axis_tdata[IN_VEL_LSB +: 32];
            r_s0_kp   <= i_s_axis_tdata[IN_KP_LSB +: KP_W];
            r_s0_kd   <= i_s_axis_tdata[IN_KD_LSB +: KD_W];
            r_s0_tq   <= i_s_axis_tdata[IN_TQ_LSB +: 32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp to offset binary, float magnitudes
    // ------------------------------------------------------------------
    logic [20:0] n_s1_u_pos;
    logic [22:0] n_s1_u_vel;
    logic [20:0] n_s1_u_tq;

    always_comb begin
        if (r_s0_pos > POS_LIM) begin
            n_s1_u_pos = POS_UMAX;
        end else if (r_s0_pos < POS_LIM_N) begin
            n_s1_u_pos = '0;
        end else begin
            n_s1_u_pos = r_s0_pos[20:0] + POS_OFS;
        end

        if (r_s0_vel > VEL_LIM) begin
            n_s1_u_vel = VEL_UMAX;
        end else if (r_s0_vel < VEL_LIM_N) begin
            n_s1_u_vel = '0;
        end else begin
            n_s1_u_vel = r_s0_vel[22:0] + VEL_OFS;
        end

        if (r_s0_tq > TQ_LIM) begin
            n_s1_u_tq = TQ_UMAX;
        end else if (r_s0_tq < TQ_LIM_N) begin
            n_s1_u_tq = '0;
        end else begin
            n_s1_u_tq = r_s0_tq[20:0] + TQ_OFS;
        end
    end

    logic [7:0]      r_s1_id;
    logic [1:0]      r_s1_mode;
    logic [20:0]     r_s1_u_pos;
    logic [22:0]     r_s1_u_vel;
    logic [20:0]     r_s1_u_tq;
    logic [KP_W-1:0] r_s1_kp;
    logic [KD_W-1:0] r_s1_kd;
    t_f32_mag        r_s1_fp;
    t_f32_mag        r_s1_fv;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[1]) begin
            r_s1_id    <= r_s0_id;
            r_s1_mode  <= r_s0_mode;
            r_s1_u_pos <= n_s1_u_pos;
            r_s1_u_vel <= n_s1_u_vel;
            r_s1_u_tq  <= n_s1_u_tq;
            r_s1_kp    <= r_s0_kp;
            r_s1_kd    <= r_s0_kd;
            r_s1_fp    <= f_f32_mag(r_s0_pos);
            r_s1_fv    <= f_f32_mag(r_s0_vel);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by the code range and drop 16 fraction bits,
    // leading-one search for the float paths
    // ------------------------------------------------------------------
    logic [36:0] n_s2_t_pos;
    logic [34:0] n_s2_t_vel;
    logic [32:0] n_s2_t_tq;
    logic [36:0] n_s2_t_kp;
    logic [30:0] n_s2_t_kd;
    t_f32_lzc    n_s2_fp;
    t_f32_lzc    n_s2_fv;

    always_comb begin
        // x * 65535 and x * 4095 as shift and subtract
        n_s2_t_pos = {r_s1_u_pos, 16'd0} - 37'(r_s1_u_pos);
        n_s2_t_vel = {r_s1_u_vel, 12'd0} - 35'(r_s1_u_vel);
        n_s2_t_tq  = {r_s1_u_tq, 12'd0} - 33'(r_s1_u_tq);
        n_s2_t_kp  = {r_s1_kp, 12'd0} - 37'(r_s1_kp);
        n_s2_t_kd  = {r_s1_kd, 12'd0} - 31'(r_s1_kd);

        n_s2_fp.sign = r_s1_fp.sign;
        n_s2_fp.zero = (r_s1_fp.mag == 32'd0);
        n_s2_fp.mag  = r_s1_fp.mag;
        n_s2_fp.msb  = f_msb_index(r_s1_fp.mag);
        n_s2_fv.sign = r_s1_fv.sign;
        n_s2_fv.zero = (r_s1_fv.mag == 32'd0);
        n_s2_fv.mag  = r_s1_fv.mag;
        n_s2_fv.msb  = f_msb_index(r_s1_fv.mag);
    end

    logic [7:0]  r_s2_id;
    logic [1:0]  r_s2_mode;
    logic [20:0] r_s2_w_pos;
    logic [18:0] r_s2_w_vel;
    logic [16:0] r_s2_w_tq;
    logic [20:0] r_s2_w_kp;
    logic [14:0] r_s2_w_kd;
    t_f32_lzc    r_s2_fp;
    t_f32_lzc    r_s2_fv;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[2]) begin
            r_s2_id    <= r_s1_id;
            r_s2_mode  <= r_s1_mode;
            r_s2_w_pos <= n_s2_t_pos[36:16];
            r_s2_w_vel <= n_s2_t_vel[34:16];
            r_s2_w_tq  <= n_s2_t_tq[32:16];
            r_s2_w_kp  <= n_s2_t_kp[36:16];
            r_s2_w_kd  <= n_s2_t_kd[30:16];
            r_s2_fp    <= n_s2_fp;
            r_s2_fv    <= n_s2_fv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate by reciprocal, normalising shift
    // ------------------------------------------------------------------
    logic [48:0] n_s3_p_pos;
    logic [44:0] n_s3_p_vel;
    logic [44:0] n_s3_p_tq;
    logic [44:0] n_s3_p_kp;
    logic [44:0] n_s3_p_kd;
    t_f32_norm   n_s3_fp;
    t_f32_norm   n_s3_fv;

    always_comb begin
        n_s3_p_pos = 49'(r_s2_w_pos) * 49'(POS_RECIP);
        n_s3_p_vel = 45'(r_s2_w_vel) * 45'(VEL_RECIP);
        n_s3_p_tq  = 45'(r_s2_w_tq) * 45'(TQ_RECIP);
        n_s3_p_kp  = 45'(r_s2_w_kp) * 45'(KP_RECIP);
        n_s3_p_kd  = 45'(r_s2_w_kd) * 45'(KD_RECIP);

        n_s3_fp.sign = r_s2_fp.sign;
        n_s3_fp.zero = r_s2_fp.zero;
        n_s3_fp.expo = 8'(r_s2_fp.msb) + F32_EXP_BASE;
        n_s3_fp.norm = r_s2_fp.mag << (5'd31 - r_s2_fp.msb);
        n_s3_fv.sign = r_s2_fv.sign;
        n_s3_fv.zero = r_s2_fv.zero;
        n_s3_fv.expo = 8'(r_s2_fv.msb) + F32_EXP_BASE;
        n_s3_fv.norm = r_s2_fv.mag << (5'd31 - r_s2_fv.msb);
    end

    logic [7:0]  r_s3_id;
    logic [1:0]  r_s3_mode;
    logic [20:0] r_s3_w_pos;
    logic [18:0] r_s3_w_vel;
    logic [16:0] r_s3_w_tq;
    logic [20:0] r_s3_w_kp;
    logic [14:0] r_s3_w_kd;
    logic [15:0] r_s3_q_pos;
    logic [11:0] r_s3_q_vel;
    logic [11:0] r_s3_q_tq;
    logic [12:0] r_s3_q_kp;
    logic [12:0] r_s3_q_kd;
    t_f32_norm   r_s3_fp;
    t_f32_norm   r_s3_fv;

    always_ff @(posedge i_clk) begin
        if (stage_rdy[3]) begin
            r_s3_id    <= r_s2_id;
            r_s3_mode  <= r_s2_mode;
            r_s3_w_pos <= r_s2_w_pos;
            r_s3_w_vel <= r_s2_w_vel;
            r_s3_w_tq  <= r_s2_w_tq;
            r_s3_w_kp  <= r_s2_w_kp;
            r_s3_w_kd  <= r_s2_w_kd;
            r_s3_q_pos <= n_s3_p_pos[47:32];
            r_s3_q_vel <= n_s3_p_vel[43:32];
            r_s3_q_tq  <= n_s3_p_tq[43:32];
            r_s3_q_kp  <= n_s3_p_kp[44:32];
            r_s3_q_kd  <= n_s3_p_kd[44:32];
            r_s3_fp    <= n_s3_fp;
            r_s3_fv    <= n_s3_fv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: quotient correction, gain saturation, rounding, packing
    // ------------------------------------------------------------------
    logic [20:0] rem_pos;
    logic [18:0] rem_vel;
    logic [16:0] rem_tq;
    logic [20:0] rem_kp;
    logic [14:0] rem_kd;
    logic [15:0] code_pos;
    logic [11:0] code_vel;
    logic [11:0] code_tq;
    logic [12:0] q_kp;
    logic [12:0] q_kd;
    logic [11:0] code_kp;
    logic [11:0] code_kd;
    logic [31:0] f32_pos;
    logic [31:0] f32_vel;
    logic [OUT_FID_W-1:0] n_fid;
    logic [7:0]  n_byte [OUT_BYTES];

    always_comb begin
        // estimate is exact or one short
        rem_pos = r_s3_w_pos - 21'(21'(r_s3_q_pos) * 21'(POS_DIV));
        rem_vel = r_s3_w_vel - 19'(19'(r_s3_q_vel) * 19'(VEL_DIV));
        rem_tq  = r_s3_w_tq - 17'(17'(r_s3_q_tq) * 17'(TQ_DIV));
        rem_kp  = r_s3_w_kp - 21'(21'(r_s3_q_kp) * 21'(KP_DIV));
        rem_kd  = r_s3_w_kd - 15'(15'(r_s3_q_kd) * 15'(KD_DIV));

        code_pos = (rem_pos >= 21'(POS_DIV)) ? r_s3_q_pos + 16'd1 : r_s3_q_pos;
        code_vel = (rem_vel >= 19'(VEL_DIV)) ? r_s3_q_vel + 12'd1 : r_s3_q_vel;
        code_tq  = (rem_tq >= 17'(TQ_DIV)) ? r_s3_q_tq + 12'd1 : r_s3_q_tq;
        q_kp     = (rem_kp >= 21'(KP_DIV)) ? r_s3_q_kp + 13'd1 : r_s3_q_kp;
        q_kd     = (rem_kd >= 15'(KD_DIV)) ? r_s3_q_kd + 13'd1 : r_s3_q_kd;

        // gains beyond their nominal span saturate
        code_kp = (q_kp > 13'(CODE12_MAX)) ? CODE12_MAX : q_kp[11:0];
        code_kd = (q_kd > 13'(CODE12_MAX)) ? CODE12_MAX : q_kd[11:0];

        f32_pos = f_f32_round(r_s3_fp);
        f32_vel = f_f32_round(r_s3_fv);

        case (r_s3_mode)
            MODE_POS_VEL: begin
                n_fid = 10'(r_s3_id) + PV_OFFSET;
                n_byte[0] = f32_pos[7:0];
                n_byte[1] = f32_pos[15:8];
                n_byte[2] = f32_pos[23:16];
                n_byte[3] = f32_pos[31:24];
                n_byte[4] = f32_vel[7:0];
                n_byte[5] = f32_vel[15:8];
                n_byte[6] = f32_vel[23:16];
                n_byte[7] = f32_vel[31:24];
            end
            MODE_VEL: begin
                n_fid = 10'(r_s3_id) + V_OFFSET;
                n_byte[0] = f32_vel[7:0];
                n_byte[1] = f32_vel[15:8];
                n_byte[2] = f32_vel[23:16];
                n_byte[3] = f32_vel[31:24];
                n_byte[4] = 8'd0;
                n_byte[5] = 8'd0;
                n_byte[6] = 8'd0;
                n_byte[7] = 8'd0;
            end
            default: begin
                // MIT frame, codes packed big-endian
                n_fid = 10'(r_s3_id);
                n_byte[0] = code_pos[15:8];
                n_byte[1] = code_pos[7:0];
                n_byte[2] = code_vel[11:4];
                n_byte[3] = {code_vel[3:0], code_kp[11:8]};
                n_byte[4] = code_kp[7:0];
                n_byte[5] = code_kd[11:4];
                n_byte[6] = {code_kd[3:0], code_tq[11:8]};
                n_byte[7] = code_tq[7:0];
            end
        endcase
    end

    logic [OUT_FID_W-1:0] r_out_fid;
    logic [7:0]           r_out_byte [OUT_BYTES];

    always_ff @(posedge i_clk) begin
        if (stage_rdy[LAST]) begin
            r_out_fid <= n_fid;
            for (int b = 0; b < OUT_BYTES; b++) begin
                r_out_byte[b] <= n_byte[b];
            end
        end
    end

    assign o_m_axis_tdata = {
        (OUT_TDATA_W - OUT_FID_W - 8 * OUT_BYTES)'(0),
        r_out_byte[7], r_out_byte[6], r_out_byte[5], r_out_byte[4],
        r_out_byte[3], r_out_byte[2], r_out_byte[1], r_out_byte[0],
        r_out_fid
    };

`ifndef SYNTH
    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    // an empty output register must leave the input open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // reciprocal estimates are never more than one short
    a_recip_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (rem_pos < 21'(2 * POS_DIV)))
        else $error("position quotient estimate off by more than one");

    a_recip_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (rem_vel < 19'(2 * VEL_DIV)))
        else $error("velocity quotient estimate off by more than one");

    // a non-zero value must arrive normalised at the rounding step
    a_norm_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r_s3_fp.zero) |-> r_s3_fp.norm[31])
        else $error("position float not normalised");

    // velocity frames carry nothing in the upper half of the payload
    a_vel_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_out_fid[9:8] == V_OFFSET[9:8]))
        |-> (o_m_axis_tdata[73:42] == 32'd0))
        else $error("velocity frame with non-zero upper payload");
`endif

endmodule

`default_nettype wire

@@ test/frame_checker.sv @@
// ----------------------------------------------------------------------------
// frame_checker - scoreboard for the motor command frame encoder
// Watches both stream channels. Every accepted command is encoded into the
// CAN identifier and payload it should produce, and the predicted frames
// are queued in order. Each frame leaving the block is compared field by
// field with the oldest one queued. Failures are counted for the top.
// ----------------------------------------------------------------------------

module frame_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    input  logic                                  i_s_tready,
    // motor_id, position, velocity, stiffness_gain, damping_gain, torque, pad
    input  logic [mcfe_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // mode
    input  logic [mcfe_pkg::IN_TUSER_W-1:0]       i_s_tuser,
    input  logic                                  i_m_tvalid,
    input  logic                                  i_m_tready,
    // frame_identifier, byte0 .. byte7, pad
    input  logic [mcfe_pkg::OUT_TDATA_W-1:0]      i_m_tdata,
    output int                                    o_failures,
    output int                                    o_pending,
    output int                                    o_frames_checked
);

    // Full-scale gains in Q16 and quantiser code maxima
    localparam longint KP_SPAN     = 64'd500 * 64'd65536;
    localparam longint KD_SPAN     = 64'd5 * 64'd65536;
    localparam longint CODE12_TOP  = 64'd4095;
    localparam longint CODE16_TOP  = 64'd65535;
    localparam int     SINGLE_BIAS = 111;   // 127 less the 16 fraction bits

    typedef struct packed {
        logic [9:0]      frame_id;
        logic [7:0][7:0] payload;   // payload[0] is byte0
    } can_frame_t;

    can_frame_t expected_frames[$];
    int failures       = 0;
    int pending        = 0;
    int frames_checked = 0;

    assign o_failures       = failures;
    assign o_pending        = pending;
    assign o_frames_checked = frames_checked;

    // One line per failure
    task automatic report_failure(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        failures++;
    endtask

    // Clamp a signed Q16 value to +/-lim and scale to an offset-binary code
    function automatic longint quantise_offset(input logic [31:0] raw, input longint lim,
                                               input longint code_top);
        longint x;
        x = $signed(raw);
        if (x > lim) begin
            x = lim;
        end else if (x < -lim) begin
            x = -lim;
        end
        return ((x + lim) * code_top) / (2 * lim);
    endfunction

    // Unsigned gain to a 12-bit code, saturating above full scale
    function automatic longint quantise_gain(input longint gain, input longint span);
        longint code;
        code = (gain * CODE12_TOP) / span;
        return (code > CODE12_TOP) ? CODE12_TOP : code;
    endfunction

    // Signed Q16 to IEEE single, round to nearest even
    function automatic logic [31:0] q16_to_binary32(input logic [31:0] raw);
        longint     v;
        longint     mag;
        longint     rem;
        longint     half;
        longint     q;
        logic       neg;
        logic [7:0] expo;
        int         msb;
        int         sh;
        v = $signed(raw);
        if (v == 0) begin
            return 32'd0;
        end
        neg = (v < 0);
        mag = neg ? -v : v;
        msb = 0;
        while ((mag >> (msb + 1)) != 0) begin
            msb++;
        end
        expo = 8'(msb + SINGLE_BIAS);
        if (msb <= 23) begin
            q = mag << (23 - msb);
        end else begin
            sh   = msb - 23;
            rem  = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            q    = mag >> sh;
            if (rem > half || (rem == half && q[0])) begin
                q++;
            end
            // rounding carried into a new binade
            if (q == (64'd1 << 24)) begin
                q = q >> 1;
                expo++;
            end
        end
        return {neg, expo, q[22:0]};
    endfunction

    // Frame that one command should produce
    function automatic can_frame_t encode_frame(input logic [mcfe_pkg::IN_TDATA_W-1:0] word,
                                                input logic [1:0] mode);
        can_frame_t  f;
        logic [7:0]  id;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] trq;
        logic [15:0] pos_code;
        logic [11:0] vel_code;
        logic [11:0] kp_code;
        logic [11:0] kd_code;
        logic [11:0] trq_code;
        id  = word[mcfe_pkg::IN_ID_LSB +: 8];
        pos = word[mcfe_pkg::IN_POS_LSB +: 32];
        vel = word[mcfe_pkg::IN_VEL_LSB +: 32];
        trq = word[mcfe_pkg::IN_TQ_LSB +: 32];
        f   = '0;
        if (mode == mcfe_pkg::MODE_POS_VEL) begin
            f.frame_id = 10'(id) + mcfe_pkg::PV_OFFSET;
            f.payload  = {q16_to_binary32(vel), q16_to_binary32(pos)};
        end else if (mode == mcfe_pkg::MODE_VEL) begin
            f.frame_id = 10'(id) + mcfe_pkg::V_OFFSET;
            f.payload  = {32'd0, q16_to_binary32(vel)};
        end else begin
            // MIT layout, big-endian codes
            pos_code = 16'(quantise_offset(pos, longint'(mcfe_pkg::POS_LIM), CODE16_TOP));
            vel_code = 12'(quantise_offset(vel, longint'(mcfe_pkg::VEL_LIM), CODE12_TOP));
            trq_code = 12'(quantise_offset(trq, longint'(mcfe_pkg::TQ_LIM), CODE12_TOP));
            kp_code  = 12'(quantise_gain(longint'(word[mcfe_pkg::IN_KP_LSB +: mcfe_pkg::KP_W]),
                                         KP_SPAN));
            kd_code  = 12'(quantise_gain(longint'(word[mcfe_pkg::IN_KD_LSB +: mcfe_pkg::KD_W]),
                                         KD_SPAN));
            f.frame_id   = 10'(id);
            f.payload[0] = pos_code[15:8];
            f.payload[1] = pos_code[7:0];
            f.payload[2] = vel_code[11:4];
            f.payload[3] = {vel_code[3:0], kp_code[11:8]};
            f.payload[4] = kp_code[7:0];
            f.payload[5] = kd_code[11:4];
            f.payload[6] = {kd_code[3:0], trq_code[11:8]};
            f.payload[7] = trq_code[7:0];
        end
        return f;
    endfunction

    // Compare leaving frames first, then queue the prediction for a new command
    always @(posedge i_clk) begin : channel_monitor
        can_frame_t seen;
        can_frame_t want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                // identifier sits in the low bits, payload bytes above it
                seen = {i_m_tdata[mcfe_pkg::OUT_FID_W-1:0],
                        i_m_tdata[mcfe_pkg::OUT_FID_W + 64 - 1:mcfe_pkg::OUT_FID_W]};
                if (expected_frames.size() == 0) begin
                    report_failure($sformatf("frame id %03h arrived with no command outstanding",
                                             seen.frame_id));
                end else begin
                    want = expected_frames.pop_front();
                    if (seen.frame_id !== want.frame_id) begin
                        report_failure($sformatf("frame %0d identifier: got %03h want %03h",
                                                 frames_checked, seen.frame_id, want.frame_id));
                    end
                    for (int k = 0; k < mcfe_pkg::OUT_BYTES; k++) begin
                        if (seen.payload[k] !== want.payload[k]) begin
                            report_failure($sformatf("frame %0d byte%0d: got %02h want %02h",
                                                     frames_checked, k, seen.payload[k],
                                                     want.payload[k]));
                        end
                    end
                    frames_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_frames.push_back(encode_frame(i_s_tdata, i_s_tuser));
            end
        end
        pending = expected_frames.size();
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - motor command frame encoder regression
// Drives directed corner commands (clamp limits, gain saturation, float
// rounding ties, identifier offsets) and then random commands in phases with
// and without sender gaps and receiver stalls. The frame_checker scoreboard
// predicts and compares every frame; this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

    // Mode codes for MIT mode; both are encoded the same way
    localparam logic [1:0] MODE_MIT     = 2'd0;
    localparam logic [1:0] MODE_MIT_ALT = 2'd3;

    localparam int PHASE_ITEMS = 200;         // four random phases
    localparam int KP_FULL     = 32768000;    // 500.0 in Q16
    localparam int KD_FULL     = 327680;      // 5.0 in Q16
    localparam int RUN_LIMIT   = 5000000;

    typedef struct packed {
        logic [7:0]  motor_id;
        logic [1:0]  mode;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [24:0] stiffness;
        logic [18:0] damping;
        logic [31:0] torque;
    } motor_cmd_t;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [mcfe_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
    logic [mcfe_pkg::IN_TUSER_W-1:0]    s_tuser  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [mcfe_pkg::OUT_TDATA_W-1:0]   m_tdata;

    int failure_count;
    int frames_pending;
    int frames_checked;

    logic sender_idling      = 1'b0;
    logic receiver_stalling  = 1'b0;
    int   stall_left         = 0;
    int   mit_sent           = 0;
    int   pos_vel_sent       = 0;
    int   vel_sent           = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    motor_command_frame_encoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    frame_checker frame_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .o_failures       (failure_count),
        .o_pending        (frames_pending),
        .o_frames_checked (frames_checked)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(4, 30));
    endfunction

    // Value around a clamp limit, the exact limits now and then
    function automatic logic [31:0] near_limit(input int lim);
        int span;
        span = lim + lim / 4;
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(0, 1) ? lim : -lim;
        end
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // Word of random magnitude so every exponent comes up, with some rounding ties
    function automatic logic [31:0] random_q16_word();
        logic [31:0] w;
        w = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 7) == 0) begin
            w[7:0] = 8'h80;
        end
        return $urandom_range(0, 1) ? -w : w;
    endfunction

    function automatic motor_cmd_t make_cmd(input logic [7:0] id, input logic [1:0] mode,
                                            input logic [31:0] pos, input logic [31:0] vel,
                                            input logic [24:0] kp, input logic [18:0] kd,
                                            input logic [31:0] trq);
        motor_cmd_t c;
        c.motor_id  = id;
        c.mode      = mode;
        c.position  = pos;
        c.velocity  = vel;
        c.stiffness = kp;
        c.damping   = kd;
        c.torque    = trq;
        return c;
    endfunction

    // Mostly well-formed MIT commands, float-mode commands, and raw noise
    function automatic motor_cmd_t random_command();
        motor_cmd_t c;
        int         kind;
        c    = motor_cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            c.mode     = $urandom_range(0, 1) ? MODE_MIT : MODE_MIT_ALT;
            c.position = near_limit(int'(mcfe_pkg::POS_LIM));
            c.velocity = near_limit(int'(mcfe_pkg::VEL_LIM));
            c.torque   = near_limit(int'(mcfe_pkg::TQ_LIM));
            if ($urandom_range(0, 7) != 0) begin
                c.stiffness = 25'($urandom_range(0, KP_FULL));
                c.damping   = 19'($urandom_range(0, KD_FULL));
            end
        end else if (kind == 5) begin
            c.mode = $urandom_range(0, 1) ? MODE_MIT : MODE_MIT_ALT;
        end else begin
            c.mode     = $urandom_range(0, 1) ? mcfe_pkg::MODE_POS_VEL : mcfe_pkg::MODE_VEL;
            c.position = random_q16_word();
            c.velocity = random_q16_word();
        end
        return c;
    endfunction

    // Offer one command, hold it until taken, then idle if the phase allows
    task automatic send_command(input motor_cmd_t c);
        logic [mcfe_pkg::IN_TDATA_W-1:0] word;
        int                              gap;
        word = '0;
        word[mcfe_pkg::IN_ID_LSB  +: 8]               = c.motor_id;
        word[mcfe_pkg::IN_POS_LSB +: 32]              = c.position;
        word[mcfe_pkg::IN_VEL_LSB +: 32]              = c.velocity;
        word[mcfe_pkg::IN_KP_LSB  +: mcfe_pkg::KP_W]  = c.stiffness;
        word[mcfe_pkg::IN_KD_LSB  +: mcfe_pkg::KD_W]  = c.damping;
        word[mcfe_pkg::IN_TQ_LSB  +: 32]              = c.torque;
        s_tdata  <= word;
        s_tuser  <= c.mode;
        s_tvalid <= 1'b1;
        do begin
            @(posedge clk);
        end while (!s_tready);
        if (c.mode == mcfe_pkg::MODE_POS_VEL) begin
            pos_vel_sent++;
        end else if (c.mode == mcfe_pkg::MODE_VEL) begin
            vel_sent++;
        end else begin
            mit_sent++;
        end
        @(negedge clk);
        gap = sender_idling ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Sender withdraws and holds off until every outstanding frame has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (frames_pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic run_random_phase(input logic idle_tx, input logic stall_rx);
        sender_idling     = idle_tx;
        receiver_stalling = stall_rx;
        repeat (PHASE_ITEMS) send_command(random_command());
        wait_for_drain();
    endtask

    // Receiver ready with random stalls
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (receiver_stalling && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners: midpoint, limits, saturation, identifier wrap, ties
        receiver_stalling = 1'b1;
        send_command(make_cmd(8'h01, MODE_MIT, 32'd0, 32'd0, 25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h7F, MODE_MIT, mcfe_pkg::POS_LIM, mcfe_pkg::VEL_LIM,
                              25'(KP_FULL), 19'(KD_FULL), mcfe_pkg::TQ_LIM));
        send_command(make_cmd(8'h80, MODE_MIT_ALT, mcfe_pkg::POS_LIM_N, mcfe_pkg::VEL_LIM_N,
                              25'd0, 19'd0, mcfe_pkg::TQ_LIM_N));
        send_command(make_cmd(8'hFF, MODE_MIT_ALT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              25'h1FF_FFFF, 19'h7_FFFF, 32'h7FFF_FFFF));
        send_command(make_cmd(8'h00, MODE_MIT, 32'h8000_0000, 32'h8000_0000,
                              25'(KP_FULL + 1), 19'(KD_FULL + 1), 32'h8000_0000));
        send_command(make_cmd(8'h55, MODE_MIT, mcfe_pkg::POS_LIM - 1, mcfe_pkg::VEL_LIM - 1,
                              25'(KP_FULL / 2), 19'(KD_FULL / 2), mcfe_pkg::TQ_LIM_N + 1));
        send_command(make_cmd(8'hAA, MODE_MIT_ALT, mcfe_pkg::POS_LIM + 1,
                              mcfe_pkg::VEL_LIM_N - 1, 25'd1, 19'd1, mcfe_pkg::TQ_LIM + 1));
        send_command(make_cmd(8'hFF, mcfe_pkg::MODE_POS_VEL, 32'd0, 32'd0,
                              25'h1FF_FFFF, 19'h7_FFFF, 32'hFFFF_FFFF));
        send_command(make_cmd(8'h00, mcfe_pkg::MODE_POS_VEL, 32'h7FFF_FFFF, 32'h8000_0000,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h3C, mcfe_pkg::MODE_POS_VEL, 32'h0000_0001, 32'hFFFF_FFFF,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h12, mcfe_pkg::MODE_POS_VEL, 32'h0100_0001, 32'h0100_0003,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h34, mcfe_pkg::MODE_POS_VEL, 32'h00FF_FFFF, 32'hFF00_0000,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h66, mcfe_pkg::MODE_POS_VEL, 32'h0001_0000, 32'hFFFF_0000,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'hFF, mcfe_pkg::MODE_VEL, 32'hDEAD_BEEF, 32'h7FFF_FFFF,
                              25'h1FF_FFFF, 19'h7_FFFF, 32'hFFFF_FFFF));
        send_command(make_cmd(8'h00, mcfe_pkg::MODE_VEL, 32'd0, 32'd0,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'h9A, mcfe_pkg::MODE_VEL, 32'd0, 32'hFEFF_FFFF,
                              25'd0, 19'd0, 32'd0));
        send_command(make_cmd(8'hC3, mcfe_pkg::MODE_VEL, 32'd0, 32'hFDFF_FFFA,
                              25'd0, 19'd0, 32'd0));
        wait_for_drain();

        // Random phases: both sides idling, back-to-back, one side at a time
        run_random_phase(1'b1, 1'b1);
        run_random_phase(1'b0, 1'b0);
        run_random_phase(1'b1, 1'b0);
        run_random_phase(1'b0, 1'b1);

        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (2 * mcfe_pkg::NUM_STAGES) @(negedge clk);

        $display("Sent %0d commands: %0d MIT, %0d position-velocity, %0d velocity.",
                 mit_sent + pos_vel_sent + vel_sent, mit_sent, pos_vel_sent, vel_sent);
        $display("Compared %0d frames across idle, stalled and back-to-back traffic.",
                 frames_checked);
        if (failure_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("Run limit reached with %0d frames outstanding.", frames_pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
